// File: sv/efsd_pkg.sv
// Shared types, codes and constants of the event frame stream decoder.
`default_nettype none

package efsd_pkg;

	// Size limits and configuration port
	localparam int MAX_DIM_DEF = 4096;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 4;
	localparam int POS_W = 12;

	localparam logic [CFG_W-1:0] ROW_COUNT_RST = 13'd1224;
	localparam logic [CFG_W-1:0] COL_COUNT_RST = 13'd1632;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 4'd1;

	// Result kinds and error codes
	localparam logic [1:0] KIND_PIXELS = 2'd0;
	localparam logic [1:0] KIND_FRAME_START = 2'd1;
	localparam logic [1:0] KIND_FRAME_END = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] ERR_ROW = 2'd0;
	localparam logic [1:0] ERR_COL = 2'd1;
	localparam logic [1:0] ERR_EOS = 2'd2;

	// Stream bytes
	localparam logic [7:0] SYNC_BYTE = 8'hF0;
	localparam logic [7:0] SYNC_LAST = 8'hFD;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	// Block alignment and header layout
	localparam logic [2:0] ALIGN_LAST = 3'd7;
	localparam logic [4:0] HDR_FIRST = 5'd8;
	localparam logic [4:0] HDR_TRIG_LAST = 5'd15;
	localparam logic [4:0] HDR_GAP_FIRST = 5'd20;
	localparam logic [4:0] HDR_GAP_LAST = 5'd23;
	localparam logic [4:0] HDR_LAST = 5'd31;

	// Body window
	localparam int WIN_BYTES = 8;
	localparam logic [3:0] WIN_FULL = 4'd8;
	localparam logic [3:0] GROUP_BYTES = 4'd5;

	// gap / 1000 as multiply by ceil(2^38 / 1000) and shift by 38
	localparam int GAP_W = 32;
	localparam int MAGIC_W = 29;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
	localparam int DIV_SHIFT = 38;
	localparam int PROD_W = GAP_W + MAGIC_W;
	localparam int QUOT_W = PROD_W - DIV_SHIFT;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_HEADER,
		PH_BODY,
		PH_SKIP,
		PH_DROP
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [31:0] pixels;
		logic [63:0] timestamp;
		logic [1:0] error_code;
	} res_t;

	typedef struct packed {
		logic [63:0] trigger;
		logic [GAP_W-1:0] gap;
	} ts_src_t;

endpackage

`default_nettype wire

// File: sv/efsd_tsdiv.sv
// Frame start timestamp: trigger time plus gap divided by 1000, two register stages.
`default_nettype none

module efsd_tsdiv (
	input wire logic clk,
	input wire efsd_pkg::ts_src_t ts_src,
	output logic [63:0] ts
);

	logic [efsd_pkg::PROD_W-1:0] prod_s1;
	logic [63:0] ts_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= ts_src.gap * efsd_pkg::DIV_MAGIC;
		ts_s2 <= ts_src.trigger
			+ 64'(prod_s1[efsd_pkg::PROD_W-1:efsd_pkg::DIV_SHIFT]);
	end

	assign ts = ts_s2;

endmodule

`default_nettype wire

// File: sv/efsd_core.sv
// Input register, header search, header capture and body group decoding.
`default_nettype none

module efsd_core #(
	parameter int MAX_DIM = efsd_pkg::MAX_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic end_of_stream,
	input wire logic [efsd_pkg::CFG_W-1:0] row_count,
	input wire logic [efsd_pkg::CFG_W-1:0] col_count,
	input wire logic q_full,
	input wire logic [63:0] ts,
	output efsd_pkg::ts_src_t ts_src,
	output logic push,
	output efsd_pkg::res_t res
);

	localparam int IDX_RAW = $clog2(MAX_DIM);
	localparam int IDX_W = (IDX_RAW < efsd_pkg::CFG_W) ? IDX_RAW : efsd_pkg::CFG_W;
	localparam int SUM_W = ((IDX_W > efsd_pkg::POS_W) ? IDX_W : efsd_pkg::POS_W) + 1;
	localparam int LIM_RAW = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (SUM_W > LIM_RAW) ? SUM_W : LIM_RAW;

	// input register
	logic s1_v_q;
	logic [7:0] byte_s1;
	logic eos_s1;
	logic proc;

	// decoder state
	efsd_pkg::phase_t phase_q, phase_nx, phase_d;
	logic [2:0] align_q, align_d;
	logic match_q, match_d;
	logic [4:0] hdr_off_q, hdr_off_d;
	logic [63:0] win_q, win_d;
	logic [3:0] fill_q, fill_d;
	logic [IDX_W-1:0] row_idx_q, row_d, col_idx_q, col_d;
	logic [63:0] trig_q;
	logic [31:0] gap_q;

	// datapath
	logic blk_hit, hdr_done;
	logic [63:0] win_new;
	logic [3:0] fill_new;
	logic [efsd_pkg::WIN_BYTES-1:0] lane_ff, lane_en;
	logic allff, frame_end, grp_go, is_row;
	logic [7:0] head;
	logic [SUM_W-1:0] row_sum, col_sum, row_ext;
	logic [CMP_W-1:0] row_lim, col_lim;
	logic row_ovf, col_ovf, grp_err;
	logic push_raw;
	efsd_pkg::res_t res_d;

	assign proc = s1_v_q && !q_full;
	assign in_stall = s1_v_q && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_v_q <= 1'b1;
		end else if (proc) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eos_s1 <= end_of_stream;
		end
	end

	// search and header decode
	assign blk_hit = (align_q == efsd_pkg::ALIGN_LAST) && match_q
		&& (byte_s1 == efsd_pkg::SYNC_LAST);
	assign hdr_done = (hdr_off_q == efsd_pkg::HDR_LAST);

	// body window: place the byte at the fill position, then look for groups
	always_comb begin
		win_new = win_q | ({56'd0, byte_s1} << {fill_q[2:0], 3'b000});
		fill_new = fill_q + 4'd1;
		for (int i = 0; i < efsd_pkg::WIN_BYTES; i++) begin
			lane_ff[i] = (win_new[8*i +: 8] == efsd_pkg::FILL_BYTE);
			lane_en[i] = (4'(i) < fill_new);
		end
		allff = &(lane_ff | ~lane_en);
		frame_end = allff && (fill_new == efsd_pkg::WIN_FULL);
		grp_go = !allff && (fill_new >= efsd_pkg::GROUP_BYTES);
		head = win_new[7:0];
		is_row = (head == efsd_pkg::FILL_BYTE);
		row_sum = SUM_W'(row_idx_q) + SUM_W'(win_new[15:8]);
		col_sum = SUM_W'(col_idx_q) + SUM_W'({head, 4'b0000});
		row_ext = SUM_W'(row_idx_q);
		row_lim = (CMP_W'(row_count) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
			: CMP_W'(row_count);
		col_lim = (CMP_W'(col_count) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
			: CMP_W'(col_count);
		row_ovf = (CMP_W'(row_sum) >= row_lim);
		col_ovf = (CMP_W'(col_sum) >= col_lim);
		grp_err = grp_go && (is_row ? row_ovf : col_ovf);
	end

	// next phase
	always_comb begin
		phase_nx = phase_q;
		unique case (phase_q)
			efsd_pkg::PH_SEARCH: if (blk_hit) phase_nx = efsd_pkg::PH_HEADER;
			efsd_pkg::PH_HEADER: if (hdr_done) phase_nx = efsd_pkg::PH_BODY;
			efsd_pkg::PH_BODY: begin
				if (frame_end) begin
					phase_nx = efsd_pkg::PH_SKIP;
				end else if (grp_err) begin
					phase_nx = efsd_pkg::PH_DROP;
				end
			end
			efsd_pkg::PH_SKIP: begin
				if (byte_s1 != efsd_pkg::FILL_BYTE) phase_nx = efsd_pkg::PH_SEARCH;
			end
			efsd_pkg::PH_DROP: phase_nx = efsd_pkg::PH_DROP;
			default: phase_nx = efsd_pkg::PH_SEARCH;
		endcase
		phase_d = eos_s1 ? efsd_pkg::PH_SEARCH : phase_nx;
	end

	// results and state updates
	always_comb begin
		align_d = align_q;
		match_d = match_q;
		hdr_off_d = hdr_off_q;
		win_d = win_q;
		fill_d = fill_q;
		row_d = row_idx_q;
		col_d = col_idx_q;
		push_raw = 1'b0;
		res_d = '0;
		unique case (phase_q)
			efsd_pkg::PH_SEARCH: begin
				align_d = align_q + 3'd1;
				match_d = (align_q == efsd_pkg::ALIGN_LAST) ? 1'b1
					: (match_q && (byte_s1 == efsd_pkg::SYNC_BYTE));
				if (blk_hit) hdr_off_d = efsd_pkg::HDR_FIRST;
			end
			efsd_pkg::PH_HEADER: begin
				if (hdr_done) begin
					push_raw = 1'b1;
					res_d.kind = efsd_pkg::KIND_FRAME_START;
					res_d.timestamp = ts;
					win_d = '0;
					fill_d = '0;
					row_d = '0;
					col_d = '0;
				end else begin
					hdr_off_d = hdr_off_q + 5'd1;
				end
			end
			efsd_pkg::PH_BODY: begin
				if (frame_end) begin
					push_raw = 1'b1;
					res_d.kind = efsd_pkg::KIND_FRAME_END;
					win_d = '0;
					fill_d = '0;
				end else if (grp_go) begin
					win_d = win_new >> 40;
					fill_d = fill_new - efsd_pkg::GROUP_BYTES;
					if (is_row) begin
						if (row_ovf) begin
							push_raw = 1'b1;
							res_d.kind = efsd_pkg::KIND_ERROR;
							res_d.error_code = efsd_pkg::ERR_ROW;
						end else begin
							row_d = row_sum[IDX_W-1:0];
							col_d = '0;
						end
					end else begin
						push_raw = 1'b1;
						if (col_ovf) begin
							res_d.kind = efsd_pkg::KIND_ERROR;
							res_d.error_code = efsd_pkg::ERR_COL;
						end else begin
							col_d = col_sum[IDX_W-1:0];
							res_d.kind = efsd_pkg::KIND_PIXELS;
							res_d.row = row_ext[efsd_pkg::POS_W-1:0];
							res_d.col = col_sum[efsd_pkg::POS_W-1:0];
							res_d.pixels = win_new[39:8];
						end
					end
				end else begin
					win_d = win_new;
					fill_d = fill_new;
				end
			end
			efsd_pkg::PH_SKIP: begin
				if (byte_s1 != efsd_pkg::FILL_BYTE) begin
					align_d = 3'd1;
					match_d = (byte_s1 == efsd_pkg::SYNC_BYTE);
				end
			end
			efsd_pkg::PH_DROP: begin
				align_d = align_q;
			end
			default: begin
				align_d = '0;
				match_d = 1'b1;
			end
		endcase
		if (eos_s1) begin
			// stream ended inside a frame: report it unless an overflow already did
			if ((phase_nx == efsd_pkg::PH_HEADER || phase_nx == efsd_pkg::PH_BODY)
				&& !(push_raw && res_d.kind == efsd_pkg::KIND_ERROR)) begin
				push_raw = 1'b1;
				res_d = '0;
				res_d.kind = efsd_pkg::KIND_ERROR;
				res_d.error_code = efsd_pkg::ERR_EOS;
			end
			align_d = '0;
			match_d = 1'b1;
			win_d = '0;
			fill_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= efsd_pkg::PH_SEARCH;
			align_q <= '0;
			match_q <= 1'b1;
			hdr_off_q <= '0;
			win_q <= '0;
			fill_q <= '0;
			row_idx_q <= '0;
			col_idx_q <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			align_q <= align_d;
			match_q <= match_d;
			hdr_off_q <= hdr_off_d;
			win_q <= win_d;
			fill_q <= fill_d;
			row_idx_q <= row_d;
			col_idx_q <= col_d;
		end
	end

	// trigger and gap bytes, little endian
	always_ff @(posedge clk) begin
		if (proc && phase_q == efsd_pkg::PH_HEADER) begin
			if (hdr_off_q >= efsd_pkg::HDR_FIRST && hdr_off_q <= efsd_pkg::HDR_TRIG_LAST) begin
				trig_q[8*(hdr_off_q[2:0]) +: 8] <= byte_s1;
			end
			if (hdr_off_q >= efsd_pkg::HDR_GAP_FIRST && hdr_off_q <= efsd_pkg::HDR_GAP_LAST) begin
				gap_q[8*(hdr_off_q[1:0]) +: 8] <= byte_s1;
			end
		end
	end

	assign ts_src.trigger = trig_q;
	assign ts_src.gap = gap_q;
	assign push = proc && push_raw;
	assign res = res_d;

endmodule

`default_nettype wire

// File: sv/efsd_outq.sv
// Two-entry result queue: output register plus skid register.
`default_nettype none

module efsd_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire efsd_pkg::res_t res,
	input wire logic out_stall,
	output logic out_valid,
	output efsd_pkg::res_t out_res,
	output logic full
);

	logic out_v_q, skid_v_q;
	efsd_pkg::res_t out_q, skid_q;
	logic pop;

	assign pop = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res = out_q;
	assign full = skid_v_q;

endmodule

`default_nettype wire

// File: sv/event_frame_stream_decoder_top.sv
// Top level of the event frame stream decoder: config registers, decoder, timestamp, result queue.
// Throughput: one stream byte per cycle while in_stall is low; a result, when a byte causes one,
// is registered in the input register, then in the output or skid register.
// The 32-byte header hides the two-stage gap/1000 multiply and timestamp add.
// Input stalls only when both the output register and the skid register hold results.
// Reset (arst_n low, asynchronous): searching for a header, no results held,
// row_count = 1224, col_count = 1632.
`default_nettype none

module event_frame_stream_decoder_top #(
	parameter int MAX_DIM = efsd_pkg::MAX_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// byte stream
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic end_of_stream,
	// results
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic [11:0] row,
	output logic [11:0] col,
	output logic [31:0] pixels,
	output logic [63:0] timestamp,
	output logic [1:0] error_code,
	// configuration writes
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [efsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [efsd_pkg::CFG_W-1:0] cfg_data
);

	logic [efsd_pkg::CFG_W-1:0] row_count_q, col_count_q;
	efsd_pkg::ts_src_t ts_src;
	logic [63:0] ts;
	logic push, q_full;
	efsd_pkg::res_t res, out_res;

	// Config writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= efsd_pkg::ROW_COUNT_RST;
			col_count_q <= efsd_pkg::COL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				efsd_pkg::REG_ROW_COUNT: row_count_q <= cfg_data;
				efsd_pkg::REG_COL_COUNT: col_count_q <= cfg_data;
				default: row_count_q <= row_count_q;
			endcase
		end
	end

	// Decoder: registers each byte, then runs search, header and body logic on it.
	efsd_core #(
		.MAX_DIM(MAX_DIM)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.row_count(row_count_q),
		.col_count(col_count_q),
		.q_full(q_full),
		.ts(ts),
		.ts_src(ts_src),
		.push(push),
		.res(res)
	);

	// Timestamp runs free; it settles well before the last header byte arrives.
	efsd_tsdiv u_tsdiv (
		.clk(clk),
		.ts_src(ts_src),
		.ts(ts)
	);

	// Hold results here so the decoder keeps taking bytes while one waits.
	efsd_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.res(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_res(out_res),
		.full(q_full)
	);

	assign kind = out_res.kind;
	assign row = out_res.row;
	assign col = out_res.col;
	assign pixels = out_res.pixels;
	assign timestamp = out_res.timestamp;
	assign error_code = out_res.error_code;

	// Input stalls only while the result queue holds two items.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_error_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == efsd_pkg::KIND_ERROR) |-> (error_code != 2'd3))
		else $error("undefined error code");

	a_ts_only_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != efsd_pkg::KIND_FRAME_START) |-> (timestamp == 64'd0))
		else $error("timestamp on a result that is not a frame start");

	a_pixels_only_on_group: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != efsd_pkg::KIND_PIXELS) |-> (pixels == 32'd0 && row == 12'd0))
		else $error("pixel payload on a result that is not a pixel group");

endmodule

`default_nettype wire

// File: dv/efsd_tb_pkg.sv
`timescale 1ns / 1ps
// Frame decoder predictor and result scoreboard for the event frame stream decoder bench.
package efsd_tb_pkg;
	import efsd_pkg::*;

	class frame_scoreboard;
		localparam logic [63:0] SYNC_BLOCK = {SYNC_LAST, {7{SYNC_BYTE}}};
		localparam int REPORT_LIMIT = 10;

		logic [CFG_W-1:0] row_count;
		logic [CFG_W-1:0] col_count;

		phase_t phase;
		logic [2:0] align_cnt;
		logic [4:0] hdr_off;
		logic [63:0] window;
		logic [3:0] fill;
		logic [POS_W-1:0] row_idx;
		logic [POS_W-1:0] col_idx;
		logic [63:0] trigger;
		logic [GAP_W-1:0] gap;

		res_t expected_results[$];
		int failures;

		function new();
			row_count = ROW_COUNT_RST;
			col_count = COL_COUNT_RST;
			phase = PH_SEARCH;
			align_cnt = '0;
			hdr_off = '0;
			window = '0;
			fill = '0;
			row_idx = '0;
			col_idx = '0;
			trigger = '0;
			gap = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_ROW_COUNT: row_count = val;
				REG_COL_COUNT: col_count = val;
				default: ;
			endcase
		endfunction

		function int clamp_dim(logic [CFG_W-1:0] v);
			return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Advance the decoder by one accepted stream byte and queue what it emits.
		function void note_byte(logic [7:0] b, logic eos);
			res_t r;
			bit has;
			bit allff;
			logic [63:0] mask;
			int sum;
			r = '0;
			has = 0;
			case (phase)
				PH_SEARCH: begin
					window |= 64'(b) << (8 * align_cnt);
					if (align_cnt == ALIGN_LAST) begin
						if (window == SYNC_BLOCK) begin
							phase = PH_HEADER;
							hdr_off = HDR_FIRST;
							trigger = '0;
							gap = '0;
						end
						align_cnt = '0;
						window = '0;
					end else begin
						align_cnt++;
					end
				end
				PH_HEADER: begin
					if (hdr_off <= HDR_TRIG_LAST)
						trigger |= 64'(b) << (8 * (hdr_off - HDR_FIRST));
					else if (hdr_off >= HDR_GAP_FIRST && hdr_off <= HDR_GAP_LAST)
						gap |= 32'(b) << (8 * (hdr_off - HDR_GAP_FIRST));
					if (hdr_off == HDR_LAST) begin
						r.kind = KIND_FRAME_START;
						r.timestamp = trigger + 64'(gap / 1000);
						has = 1;
						phase = PH_BODY;
						row_idx = '0;
						col_idx = '0;
						window = '0;
						fill = '0;
					end else begin
						hdr_off++;
					end
				end
				PH_BODY: begin
					window |= 64'(b) << (8 * fill[2:0]);
					fill++;
					mask = (fill >= WIN_FULL) ? '1 : ((64'd1 << (8 * fill)) - 64'd1);
					allff = (window & mask) == mask;
					if (allff && fill >= WIN_FULL) begin
						r.kind = KIND_FRAME_END;
						has = 1;
						phase = PH_SKIP;
						window = '0;
						fill = '0;
					end else if (!allff && fill >= GROUP_BYTES) begin
						if (window[7:0] == FILL_BYTE) begin
							sum = row_idx + window[15:8];
							if (sum >= clamp_dim(row_count)) begin
								r.kind = KIND_ERROR;
								r.error_code = ERR_ROW;
								has = 1;
								phase = PH_DROP;
							end else begin
								row_idx = sum[POS_W-1:0];
								col_idx = '0;
							end
						end else begin
							sum = col_idx + 16 * window[7:0];
							if (sum >= clamp_dim(col_count)) begin
								r.kind = KIND_ERROR;
								r.error_code = ERR_COL;
								has = 1;
								phase = PH_DROP;
							end else begin
								col_idx = sum[POS_W-1:0];
								r.kind = KIND_PIXELS;
								r.row = row_idx;
								r.col = col_idx;
								r.pixels = window[39:8];
								has = 1;
							end
						end
						window >>= 40;
						fill -= GROUP_BYTES;
					end
				end
				PH_SKIP: begin
					if (b != FILL_BYTE) begin
						phase = PH_SEARCH;
						window = 64'(b);
						align_cnt = 3'd1;
					end
				end
				PH_DROP: ;
				default: begin
					phase = PH_SEARCH;
					align_cnt = '0;
					window = '0;
				end
			endcase
			// an overflow on the last byte wins over the stream-ended error
			if (eos) begin
				if ((phase == PH_HEADER || phase == PH_BODY) && !(has && r.kind == KIND_ERROR)) begin
					r = '0;
					r.kind = KIND_ERROR;
					r.error_code = ERR_EOS;
					has = 1;
				end
				phase = PH_SEARCH;
				align_cnt = '0;
				hdr_off = '0;
				window = '0;
				fill = '0;
			end
			if (has)
				expected_results.push_back(r);
		endfunction

		function string show(res_t r);
			return $sformatf("kind %0d row %0d col %0d pixels %h ts %h err %0d",
				r.kind, r.row, r.col, r.pixels, r.timestamp, r.error_code);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = expected_results.pop_front();
			if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
					got.pixels !== want.pixels || got.timestamp !== want.timestamp ||
					got.error_code !== want.error_code) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("result mismatch, expected: %s", show(want));
					$display("                 actual:   %s", show(got));
				end
			end
		endfunction
	endclass

endpackage

// File: dv/tb_event_frame_stream_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking bench of the event frame stream decoder top level.
module tb_event_frame_stream_decoder_top;
	import efsd_pkg::*;
	import efsd_tb_pkg::*;

	// Results leave through the input and output registers; give generous slack before
	// touching the registers or ending the run.
	localparam int DRAIN_CYCLES = 10;
	// Random buffers per register setting.
	localparam int RANDOM_BUFFERS_PER_SETTING = 1;

	logic clk = 1'b0;
	logic arst_n;

	logic in_valid;
	logic in_stall;
	logic [7:0] data_byte;
	logic end_of_stream;

	logic out_valid;
	logic out_stall;
	logic [1:0] kind;
	logic [11:0] row;
	logic [11:0] col;
	logic [31:0] pixels;
	logic [63:0] timestamp;
	logic [1:0] error_code;

	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	frame_scoreboard board;

	// Bytes of the buffer being built; the last one sent carries end_of_stream.
	logic [7:0] buffer_bytes[$];
	bit in_burst;
	int cur_cols;

	event_frame_stream_decoder_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stream builders: append encoded pieces to buffer_bytes
	// ---------------------------------------------------------------

	function automatic void push_sync();
		repeat (7) buffer_bytes.push_back(SYNC_BYTE);
		buffer_bytes.push_back(SYNC_LAST);
	endfunction

	// Header bytes 8..31: trigger time little endian, four spare bytes, gap word,
	// then eight more spare bytes filled with noise.
	function automatic void push_header(logic [63:0] trig, logic [31:0] gap_word);
		for (int off = HDR_FIRST; off <= HDR_LAST; off++) begin
			if (off <= HDR_TRIG_LAST)
				buffer_bytes.push_back(trig[8 * (off - HDR_FIRST) +: 8]);
			else if (off >= HDR_GAP_FIRST && off <= HDR_GAP_LAST)
				buffer_bytes.push_back(gap_word[8 * (off - HDR_GAP_FIRST) +: 8]);
			else
				buffer_bytes.push_back(8'($urandom));
		end
	endfunction

	function automatic void push_pixels(logic [7:0] head, logic [31:0] pix);
		buffer_bytes.push_back(head);
		for (int i = 0; i < 4; i++)
			buffer_bytes.push_back(pix[8 * i +: 8]);
	endfunction

	function automatic void push_row_step(logic [7:0] step);
		buffer_bytes.push_back(FILL_BYTE);
		buffer_bytes.push_back(step);
		repeat (3) buffer_bytes.push_back(8'($urandom));
	endfunction

	function automatic void push_frame_end(int extra);
		repeat (8 + extra) buffer_bytes.push_back(FILL_BYTE);
	endfunction

	// Avoid 0xFF where the noise follows a frame end, else it would be skipped.
	function automatic void push_noise(int n, bit no_fill);
		repeat (n) buffer_bytes.push_back(no_fill ? 8'($urandom_range(0, 254)) : 8'($urandom));
	endfunction

	// Well-formed frame with random content. Heads mostly stay small enough to
	// walk a few groups across the row; now and then one is large to force a
	// column overflow, and a large row step forces a row overflow.
	function automatic void push_random_frame();
		int head_max;
		logic [63:0] trig;
		logic [31:0] gap_word;
		head_max = cur_cols / 96;
		trig = {$urandom, $urandom};
		gap_word = $urandom;
		case ($urandom_range(0, 7))
			0: trig = '1;
			1: gap_word = '1;
			2: begin
				trig = '1;
				gap_word = '1;
			end
			3: gap_word = $urandom_range(0, 1999);
			default: ;
		endcase
		push_sync();
		push_header(trig, gap_word);
		repeat ($urandom_range(0, 10)) begin
			if ($urandom_range(0, 3) == 0)
				push_row_step(($urandom_range(0, 7) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 2)));
			else
				push_pixels(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 254)) :
					8'($urandom_range(0, head_max)), $urandom);
		end
		// leave some frames open so the stream ends inside them
		if ($urandom_range(0, 7) != 0)
			push_frame_end($urandom_range(0, 3));
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Offer one byte after a random gap and hold it until the decoder takes it.
	// Sample the handshake at the falling edge so the accepting rising edge is
	// known without racing the design's own updates.
	task automatic feed_byte(logic [7:0] b, logic eos);
		int wait_cycles;
		bit taken;
		wait_cycles = in_burst ? 0 : $urandom_range(0, 9);
		if (wait_cycles > 0) begin
			in_valid <= 1'b0;
			repeat (wait_cycles) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		board.note_byte(b, eos);
	endtask

	// Send the built buffer, optionally cut short, and mark its last byte.
	task automatic send_buffer(bit cut);
		int n;
		n = buffer_bytes.size();
		if (cut && n > 1)
			n = $urandom_range(1, n - 1);
		in_burst = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++)
			feed_byte(buffer_bytes[i], i == n - 1);
		buffer_bytes.delete();
	endtask

	// Drop valid, wait for every expected result, then let in-flight bytes that
	// produce nothing clear the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both frame dimensions, in random order; only called while idle.
	task automatic write_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
		logic [CFG_IDX_W-1:0] idx[2];
		logic [CFG_W-1:0] val[2];
		bit swap;
		bit taken;
		swap = $urandom_range(0, 1);
		idx[0] = swap ? REG_COL_COUNT : REG_ROW_COUNT;
		val[0] = swap ? cols : rows;
		idx[1] = swap ? REG_ROW_COUNT : REG_COL_COUNT;
		val[1] = swap ? rows : cols;
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do begin
				@(negedge clk);
				taken = cfg_ready;
				@(posedge clk);
			end while (!taken);
			board.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		cur_cols = cols;
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Hand-built buffers under the reset dimensions (1224 x 1632).
	task automatic run_directed();
		// Timestamp wraps with all-ones trigger and gap; heads 0, 1 and 2, pixels
		// all zero and all one, a row step, a clean end with trailing fill, then a
		// second frame whose stream ends inside the header.
		push_sync();
		push_header('1, '1);
		push_pixels(8'h00, 32'h0000_0000);
		push_pixels(8'h01, 32'hFFFF_FFFF);
		push_row_step(8'hFE);
		push_pixels(8'h02, 32'hA5C3_0F96);
		push_frame_end(2);
		push_sync();
		push_header(64'h0, 32'd999);
		buffer_bytes = buffer_bytes[0:buffer_bytes.size() - 15];
		send_buffer(0);

		// Sync pattern off the block grid: never recognized, no result.
		push_noise(3, 1);
		push_sync();
		push_noise(5, 0);
		send_buffer(0);

		// Row sum reaches the limit on the very byte that ends the stream:
		// keep the overflow, not the stream-ended error.
		push_sync();
		push_header({$urandom, $urandom}, $urandom);
		repeat (5) push_row_step(8'hFF);
		send_buffer(0);

		// Column overflow, then bytes dropped up to the end of the buffer.
		push_sync();
		push_header({$urandom, $urandom}, $urandom);
		push_pixels(8'd101, $urandom);
		push_pixels(8'd1, $urandom);
		push_noise(12, 0);
		send_buffer(0);

		// Stream ends on the byte that completes the sync block.
		push_sync();
		send_buffer(0);

		// Stream ends on the last header byte: error replaces the frame start.
		push_sync();
		push_header({$urandom, $urandom}, $urandom);
		send_buffer(0);

		// Stream ends inside a pixel group.
		push_sync();
		push_header({$urandom, $urandom}, $urandom);
		push_pixels(8'd3, $urandom);
		push_noise(2, 1);
		send_buffer(0);

		// Empty frame, stream ends on the last end-of-frame fill byte.
		push_sync();
		push_header({$urandom, $urandom}, 32'd0);
		push_frame_end(0);
		send_buffer(0);
	endtask

	// Random buffers: mostly chains of well-formed frames, some pure noise and
	// some misaligned sync blocks; a share is cut short at a random byte.
	task automatic send_random_buffer();
		int shape;
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			push_noise($urandom_range(1, 24), 0);
		end else if (shape == 1) begin
			push_noise($urandom_range(1, 7), 1);
			push_sync();
			push_noise($urandom_range(0, 16), 0);
		end else begin
			repeat ($urandom_range(1, 2)) begin
				push_noise(8 * $urandom_range(0, 1), 1);
				push_random_frame();
			end
		end
		send_buffer($urandom_range(0, 5) == 0);
	endtask

	task automatic run_dims_phase(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
		write_dims(rows, cols);
		repeat (RANDOM_BUFFERS_PER_SETTING)
			send_random_buffer();
		settle();
	endtask

	initial begin
		board = new();
		cur_cols = COL_COUNT_RST;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		end_of_stream <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROW_COUNT;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		settle();

		// Smallest and largest dimensions, a width that is not a multiple of
		// sixteen, then random ones.
		run_dims_phase(13'd1, 13'd16);
		run_dims_phase(13'd4096, 13'd4096);
		run_dims_phase(13'd8, 13'd40);
		run_dims_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(16, 4096)));
		run_dims_phase(13'($urandom_range(1, 64)), 13'(16 * $urandom_range(1, 256)));

		if (board.failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side: random stall before each result, with bursts of none
	// ---------------------------------------------------------------
	initial begin
		int hold;
		bit taken;
		bit out_burst;
		res_t got;
		out_burst = 0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				out_burst = !out_burst;
			hold = out_burst ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				taken = out_valid && !out_stall;
				got = {kind, row, col, pixels, timestamp, error_code};
				@(posedge clk);
			end while (!taken);
			board.check_result(got);
		end
	end

endmodule
